### rtl/dbia_pkg.sv
// shared types, constants and helpers for the interval admitter
package dbia_pkg;

    localparam int DEF_BOOKING_DEPTH = 64;
    localparam int DEF_DOUBLE_DEPTH  = 64;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_TRIPLE = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    load;      // capture request, restart scan
        logic    scan_dbl;  // walk the double-booking table
        logic    scan_bkg;  // walk the booking table
        logic    rewind;    // restart scan index
        logic    commit;    // store booking, advance counts
        logic    post;      // load the result register
        t_status code;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic dbl_hit;
        logic scan_done;
        logic full;
    } t_dp_sts;

    // half-open intervals [a,b) and [c,d) share an instant
    function automatic logic spans_meet(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
        spans_meet = (a < d) && (b > c);
    endfunction

endpackage

### rtl/dbia_if.sv
// valid/ready channel interfaces for requests and responses
interface dbia_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] slot_start;
    logic [31:0] slot_end;

    modport source (output valid, output slot_start, output slot_end, input ready);
    modport sink   (input valid, input slot_start, input slot_end, output ready);
endinterface

interface dbia_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] bookings_held;

    modport source (output valid, output status, output bookings_held, input ready);
    modport sink   (input valid, input status, input bookings_held, output ready);
endinterface

### rtl/dbia_ram.sv
// generic single write port ram with registered read
module dbia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/dbia_dp.sv
// datapath: request registers, table rams, scan index, counts and result register
module dbia_dp #(
    parameter int BOOKING_DEPTH = dbia_pkg::DEF_BOOKING_DEPTH,
    parameter int DOUBLE_DEPTH  = dbia_pkg::DEF_DOUBLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_slot_start,
    input  logic [31:0]       i_slot_end,
    input  dbia_pkg::t_dp_cmd i_cmd,
    output dbia_pkg::t_dp_sts o_sts,
    output logic [1:0]        o_status,
    output logic [6:0]        o_bookings_held
);
    import dbia_pkg::*;

    localparam int BAW = $clog2(BOOKING_DEPTH);
    localparam int DAW = $clog2(DOUBLE_DEPTH);
    localparam int BCW = $clog2(BOOKING_DEPTH + 1);
    localparam int DCW = $clog2(DOUBLE_DEPTH + 1);
    localparam int IW  = (BCW > DCW) ? BCW : DCW;
    localparam int SW  = IW + 1;

    logic [31:0]    r_start, r_end;
    logic [BCW-1:0] r_bcount;
    logic [DCW-1:0] r_dcount;
    logic [BCW-1:0] r_hits;
    logic [IW-1:0]  r_idx;
    logic           r_cmp_vld;
    logic [1:0]     r_status;
    logic [6:0]     r_held;

    logic [63:0]      bkg_q, dbl_q, w_q;
    logic [31:0]      w_q_s, w_q_e, w_isect_s, w_isect_e;
    logic [IW-1:0]    w_limit;
    logic             w_issue, w_meet, w_dbl_we;
    logic [SW-1:0]    w_wa;
    logic [BCW-1:0]   w_newb;
    logic [BCW+6:0]   w_newb_ext;

    always_comb begin
        w_limit    = i_cmd.scan_dbl ? IW'(r_dcount) : IW'(r_bcount);
        w_issue    = (i_cmd.scan_dbl || i_cmd.scan_bkg) && (r_idx < w_limit);
        w_q        = i_cmd.scan_dbl ? dbl_q : bkg_q;
        w_q_s      = w_q[63:32];
        w_q_e      = w_q[31:0];
        w_meet     = r_cmp_vld && spans_meet(r_start, r_end, w_q_s, w_q_e);
        w_isect_s  = (r_start > w_q_s) ? r_start : w_q_s;
        w_isect_e  = (r_end < w_q_e) ? r_end : w_q_e;
        // intersections go in past the committed count; dropped if the request is refused
        w_wa       = SW'(r_dcount) + SW'(r_hits);
        w_dbl_we   = i_cmd.scan_bkg && w_meet && (w_wa < SW'(DOUBLE_DEPTH));
        w_newb     = i_cmd.commit ? r_bcount + BCW'(1) : r_bcount;
        w_newb_ext = {7'd0, w_newb};

        o_sts.dbl_hit   = i_cmd.scan_dbl && w_meet;
        o_sts.scan_done = (r_idx >= w_limit) && !r_cmp_vld;
        o_sts.full      = (r_bcount >= BCW'(BOOKING_DEPTH)) || (w_wa > SW'(DOUBLE_DEPTH));
    end

    dbia_ram #(.WIDTH(64), .DEPTH(BOOKING_DEPTH)) u_bkg_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_bcount[BAW-1:0]),
        .i_wdata ({r_start, r_end}),
        .i_raddr (r_idx[BAW-1:0]),
        .o_rdata (bkg_q)
    );

    dbia_ram #(.WIDTH(64), .DEPTH(DOUBLE_DEPTH)) u_dbl_ram (
        .i_clk   (i_clk),
        .i_we    (w_dbl_we),
        .i_waddr (w_wa[DAW-1:0]),
        .i_wdata ({w_isect_s, w_isect_e}),
        .i_raddr (r_idx[DAW-1:0]),
        .o_rdata (dbl_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount  <= '0;
            r_dcount  <= '0;
            r_hits    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_hits    <= '0;
            end else if (i_cmd.rewind) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (i_cmd.scan_bkg && w_meet) begin
                    r_hits <= r_hits + BCW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_bcount <= w_newb;
                r_dcount <= DCW'(w_wa);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_slot_start;
            r_end   <= i_slot_end;
        end
        if (i_cmd.post) begin
            r_status <= i_cmd.code;
            r_held   <= w_newb_ext[6:0];
        end
    end

    assign o_status        = r_status;
    assign o_bookings_held = r_held;
endmodule

### rtl/dbia_ctrl.sv
// controller: sequences the two table scans, the decision and the response
module dbia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dbia_pkg::t_dp_sts i_sts,
    output dbia_pkg::t_dp_cmd o_cmd
);
    import dbia_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN_DBL = 5'b00010,
        S_SCAN_BKG = 5'b00100,
        S_DECIDE   = 5'b01000,
        S_RESP     = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.code  = ST_OK;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN_DBL;
                end
            end
            S_SCAN_DBL: begin
                o_cmd.scan_dbl = 1'b1;
                if (i_sts.dbl_hit) begin
                    o_cmd.post = 1'b1;
                    o_cmd.code = ST_TRIPLE;
                    n_state    = S_RESP;
                end else if (i_sts.scan_done) begin
                    o_cmd.rewind = 1'b1;
                    n_state      = S_SCAN_BKG;
                end
            end
            S_SCAN_BKG: begin
                o_cmd.scan_bkg = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.post   = 1'b1;
                o_cmd.commit = !i_sts.full;
                o_cmd.code   = i_sts.full ? ST_FULL : ST_OK;
                n_state      = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### rtl/double_booking_interval_admitter.sv
// top level of the interval admitter: at most double overlap of booked intervals
//
//  channel  | dir | payload                    | transfer
//  i_req    | in  | slot_start, slot_end       | valid && ready
//  o_rsp    | out | status, bookings_held      | valid && ready
//
// one request at a time: the next request is taken only after the result transfer;
// the double table is scanned first, then the booking table, then the decision is made
// an overlap in the double table ends early and skips the booking table scan
// both tables sit in rams read one entry per cycle
// reset clears both counts; table contents need no clearing
// the result is held in o_rsp until its transfer; i_req is not ready meanwhile
module double_booking_interval_admitter #(
    parameter int BOOKING_DEPTH = dbia_pkg::DEF_BOOKING_DEPTH,
    parameter int DOUBLE_DEPTH  = dbia_pkg::DEF_DOUBLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dbia_req_if.sink   i_req,
    dbia_rsp_if.source o_rsp
);
    import dbia_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dbia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dbia_dp #(
        .BOOKING_DEPTH (BOOKING_DEPTH),
        .DOUBLE_DEPTH  (DOUBLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot_start    (i_req.slot_start),
        .i_slot_end      (i_req.slot_end),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_rsp.status),
        .o_bookings_held (o_rsp.bookings_held)
    );
endmodule

### rtl/dbia_checker.sv
// port-level checks for the interval admitter, bound to the top level
module dbia_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_status,
    input logic [6:0] i_rsp_held
);
    import dbia_pkg::*;

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
                                        && $stable(i_rsp_held))
        else $error("response changed while stalled");

    // no new request while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request taken while response pending");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_TRIPLE
                         || i_rsp_status == ST_FULL))
        else $error("undefined status code");

    // a request passes through the scan states before its result
    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_rsp_valid)
        else $error("response in the cycle after request transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && i_req_ready)
        else $error("block not idle after reset");
endmodule

bind double_booking_interval_admitter dbia_checker u_dbia_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_held   (o_rsp.bookings_held)
);

### test/dbia_admission_checker.sv
// checker for the interval admitter: tracks both tables and compares every result transfer
module dbia_admission_checker #(
    parameter int BOOKING_DEPTH = dbia_pkg::DEF_BOOKING_DEPTH,
    parameter int DOUBLE_DEPTH  = dbia_pkg::DEF_DOUBLE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dbia_req_if  i_req,
    dbia_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        dbia_pkg::t_status status;
        logic [6:0]        held;
    } t_admit_result;

    logic [31:0]   bkg_lo [BOOKING_DEPTH];
    logic [31:0]   bkg_hi [BOOKING_DEPTH];
    logic [31:0]   dbl_lo [DOUBLE_DEPTH];
    logic [31:0]   dbl_hi [DOUBLE_DEPTH];
    int            bkg_count;
    int            dbl_count;
    t_admit_result admit_queue [$];

    // half-open, unsigned; inverted and empty intervals follow the same rule
    function automatic logic intervals_share(input logic [31:0] a_lo, input logic [31:0] a_hi,
                                             input logic [31:0] b_lo, input logic [31:0] b_hi);
        return (a_lo < b_hi) && (a_hi > b_lo);
    endfunction

    function automatic t_admit_result admit(input logic [31:0] lo, input logic [31:0] hi);
        t_admit_result res;
        int            hits;
        logic          blocked;
        hits    = 0;
        blocked = 1'b0;
        for (int k = 0; k < dbl_count; k++) begin
            if (intervals_share(lo, hi, dbl_lo[k], dbl_hi[k]))
                blocked = 1'b1;
        end
        for (int k = 0; k < bkg_count; k++) begin
            if (intervals_share(lo, hi, bkg_lo[k], bkg_hi[k]))
                hits++;
        end
        // triple overlap wins over any capacity test
        if (blocked) begin
            res.status = dbia_pkg::ST_TRIPLE;
        end else if (bkg_count >= BOOKING_DEPTH || hits > DOUBLE_DEPTH - dbl_count) begin
            res.status = dbia_pkg::ST_FULL;
        end else begin
            for (int k = 0; k < bkg_count; k++) begin
                if (intervals_share(lo, hi, bkg_lo[k], bkg_hi[k])) begin
                    dbl_lo[dbl_count] = (lo > bkg_lo[k]) ? lo : bkg_lo[k];
                    dbl_hi[dbl_count] = (hi < bkg_hi[k]) ? hi : bkg_hi[k];
                    dbl_count++;
                end
            end
            bkg_lo[bkg_count] = lo;
            bkg_hi[bkg_count] = hi;
            bkg_count++;
            res.status = dbia_pkg::ST_OK;
        end
        res.held = 7'(bkg_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_admit_result want;
        if (!i_rst_n) begin
            bkg_count = 0;
            dbl_count = 0;
            admit_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (admit_queue.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: status %0d held %0d",
                             $time, i_rsp.status, i_rsp.bookings_held);
                    o_fail_count++;
                end else begin
                    want = admit_queue.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (i_rsp.bookings_held !== want.held) begin
                        $display("%0t: bookings_held expected %0d actual %0d",
                                 $time, want.held, i_rsp.bookings_held);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                admit_queue.push_back(admit(i_req.slot_start, i_req.slot_end));
        end
        o_pending = admit_queue.size();
    end

endmodule

### test/double_booking_interval_admitter_tb.sv
// testbench top for the interval admitter: clock, reset, request stimulus and verdict
module double_booking_interval_admitter_tb;

    localparam int RANDOM_ITEMS = 1680;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 200;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   snd_idle_pct = 28;
    int   rcv_idle_pct = 77;
    int   quiet_cycles;

    dbia_req_if req_ch ();
    dbia_rsp_if rsp_ch ();

    double_booking_interval_admitter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dbia_admission_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
    end

    // ends the run when neither channel makes a transfer for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // returns at the falling edge after the transfer with valid still high
    task automatic offer_request(input logic [31:0] lo, input logic [31:0] hi);
        while ($urandom_range(99, 0) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.slot_start <= lo;
        req_ch.slot_end   <= hi;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        int          kind;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.slot_start = '0;
        req_ch.slot_end   = '0;
        rsp_ch.ready      = 1'b0;
        quiet_cycles      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty and inverted intervals at the ends of the range
        offer_request(32'h0000_0000, 32'h0000_0000);
        offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(32'hFFFF_FFFF, 32'h0000_0000);
        // plain overlap, then a triple inside the double region
        offer_request(32'd100, 32'd200);
        offer_request(32'd150, 32'd250);
        offer_request(32'd160, 32'd170);
        // touching edges never overlap
        offer_request(32'd200, 32'd210);
        offer_request(32'd199, 32'd200);
        offer_request(32'd250, 32'd260);
        // inverted booking, then a normal one around it
        offer_request(32'd400, 32'd300);
        offer_request(32'd0, 32'd1000);
        offer_request(32'd290, 32'd410);
        offer_request(32'd350, 32'd360);
        offer_request(32'd380, 32'd320);
        offer_request(32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(32'd1000, 32'hFFFF_FFFF);
        offer_request(32'd2000, 32'd3000);
        offer_request(32'd5000, 32'd5000);
        offer_request(32'd5000, 32'd5001);
        drain_results();

        // bookings fill early; later items check the triple scan against a full table
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                drain_results();
                snd_idle_pct = 77;
                rcv_idle_pct = 28;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            kind = $urandom_range(99, 0);
            if (kind < 15) begin
                lo = $urandom();
                hi = $urandom();
            end else if (kind < 27) begin
                hi = $urandom_range(8191, 0);
                lo = hi + $urandom_range(300, 1);
            end else if (kind < 32) begin
                lo = $urandom_range(8191, 0);
                hi = lo;
            end else begin
                lo = $urandom_range(8191, 0);
                hi = lo + ((kind < 40) ? $urandom_range(4000, 1) : $urandom_range(64, 1));
            end
            offer_request(lo, hi);
        end
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/dbia_pkg.sv
rtl/dbia_if.sv
rtl/dbia_ram.sv
rtl/dbia_dp.sv
rtl/dbia_ctrl.sv
rtl/double_booking_interval_admitter.sv
rtl/dbia_checker.sv
test/dbia_admission_checker.sv
test/double_booking_interval_admitter_tb.sv
